// ----- design/wnc_pkg.sv -----
// ----------------------------------------------------------------------------
// wnc_pkg
// Shared types and constants for the weighted nearest-codeword search:
// transfer payloads, field widths, dimension weights and the codebook ROM.
// ----------------------------------------------------------------------------
package wnc_pkg;

   localparam int NUM_DIMS          = 5;
   localparam int ROM_SIZE          = 16;
   localparam int DEF_NUM_CODEWORDS = 16;

   localparam int FIELD_W  = 10;
   localparam int WEIGHT_W = 5;
   localparam int MAG_W    = 15;
   localparam int SQ_W     = 29;
   localparam int SUM_W    = 32;
   localparam int DIST_W   = 30;
   localparam int IDX_W    = 4;

   localparam logic [WEIGHT_W-1:0] DIM_WEIGHT [NUM_DIMS] =
      '{5'd20, 5'd15, 5'd15, 5'd12, 5'd5};

   localparam logic [FIELD_W-1:0] CODEBOOK [ROM_SIZE][NUM_DIMS] = '{
      '{10'd200, 10'd900, 10'd100, 10'd900, 10'd500},
      '{10'd200, 10'd900, 10'd400, 10'd700, 10'd500},
      '{10'd200, 10'd900, 10'd600, 10'd0,   10'd500},
      '{10'd200, 10'd900, 10'd900, 10'd0,   10'd600},
      '{10'd400, 10'd600, 10'd100, 10'd800, 10'd500},
      '{10'd400, 10'd600, 10'd400, 10'd500, 10'd500},
      '{10'd400, 10'd600, 10'd600, 10'd0,   10'd500},
      '{10'd400, 10'd600, 10'd900, 10'd0,   10'd500},
      '{10'd600, 10'd400, 10'd100, 10'd700, 10'd500},
      '{10'd600, 10'd400, 10'd400, 10'd0,   10'd500},
      '{10'd500, 10'd400, 10'd600, 10'd0,   10'd500},
      '{10'd600, 10'd400, 10'd900, 10'd0,   10'd500},
      '{10'd900, 10'd100, 10'd100, 10'd0,   10'd500},
      '{10'd800, 10'd100, 10'd400, 10'd0,   10'd500},
      '{10'd800, 10'd200, 10'd700, 10'd0,   10'd500},
      '{10'd900, 10'd100, 10'd900, 10'd0,   10'd500}
   };

   typedef logic [FIELD_W-1:0] comp_type [NUM_DIMS];

   typedef struct packed {
      logic [FIELD_W-1:0] jaw_opening;
      logic [FIELD_W-1:0] tongue_rise;
      logic [FIELD_W-1:0] tongue_front;
      logic [FIELD_W-1:0] lip_round;
      logic [FIELD_W-1:0] corner_lift;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  best_index;
      logic [DIST_W-1:0] best_distance_sq;
   } rsp_type;

endpackage

// ----- design/wnc_dist_unit.sv -----
// ----------------------------------------------------------------------------
// wnc_dist_unit
// Three-stage weighted squared distance from one vector to one codeword:
// weighted magnitude, square, five-term sum.
// ----------------------------------------------------------------------------
module wnc_dist_unit (
   input  logic                       clock,
   input  logic [2:0]                 en,
   input  wnc_pkg::comp_type          vec,
   input  wnc_pkg::comp_type          codeword,
   output logic [wnc_pkg::DIST_W-1:0] dist_sq
);
   import wnc_pkg::*;

   logic [MAG_W-1:0]  mag_in [NUM_DIMS];
   logic [MAG_W-1:0]  mag_ff [NUM_DIMS];
   logic [SQ_W-1:0]   sq_in  [NUM_DIMS];
   logic [SQ_W-1:0]   sq_ff  [NUM_DIMS];
   logic [SUM_W-1:0]  sum_in;
   logic [DIST_W-1:0] sum_ff;

   always_comb begin
      for (int d = 0; d < NUM_DIMS; d++) begin
         if (vec[d] >= codeword[d]) begin
            mag_in[d] = MAG_W'(vec[d] - codeword[d]) * MAG_W'(DIM_WEIGHT[d]);
         end else begin
            mag_in[d] = MAG_W'(codeword[d] - vec[d]) * MAG_W'(DIM_WEIGHT[d]);
         end
      end
   end

   always_comb begin
      for (int d = 0; d < NUM_DIMS; d++) begin
         sq_in[d] = SQ_W'(mag_ff[d]) * SQ_W'(mag_ff[d]);
      end
   end

   always_comb begin
      sum_in = '0;
      for (int d = 0; d < NUM_DIMS; d++) begin
         sum_in = sum_in + SUM_W'(sq_ff[d]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         mag_ff <= mag_in;
      end
      if (en[1]) begin
         sq_ff <= sq_in;
      end
      if (en[2]) begin
         sum_ff <= DIST_W'(sum_in);
      end
   end

   assign dist_sq = sum_ff;

endmodule

// ----- design/wnc_min_tree.sv -----
// ----------------------------------------------------------------------------
// wnc_min_tree
// Registered minimum tree, one level per stage. The lower index wins a tie.
// ----------------------------------------------------------------------------
module wnc_min_tree #(
   parameter int NUM_LEAVES = wnc_pkg::DEF_NUM_CODEWORDS
) (
   input  logic                       clock,
   input  logic [$clog2(NUM_LEAVES)-1:0] en,
   input  logic [wnc_pkg::DIST_W-1:0] leaf_dist [NUM_LEAVES],
   output wnc_pkg::rsp_type           best
);
   import wnc_pkg::*;

   localparam int LEVELS    = $clog2(NUM_LEAVES);
   localparam int NUM_SLOTS = 1 << LEVELS;
   localparam int NUM_NODES = NUM_SLOTS - 1;

   typedef struct packed {
      logic              live;
      logic [IDX_W-1:0]  idx;
      logic [DIST_W-1:0] dist_sq;
   } node_type;

   node_type leaf_node [NUM_SLOTS];
   node_type node_in   [NUM_NODES];
   node_type node_ff   [NUM_NODES];

   for (genvar j = 0; j < NUM_SLOTS; j++) begin : g_leaf
      if (j < NUM_LEAVES) begin : g_live
         assign leaf_node[j] = '{live: 1'b1, idx: IDX_W'(j), dist_sq: leaf_dist[j]};
      end else begin : g_pad
         assign leaf_node[j] = '{live: 1'b0, idx: IDX_W'(j), dist_sq: '0};
      end
   end

   for (genvar n = 0; n < NUM_NODES; n++) begin : g_node
      localparam int LEFT  = 2 * n + 1;
      localparam int RIGHT = 2 * n + 2;
      localparam int DEPTH = $clog2(n + 2) - 1;
      localparam int STAGE = LEVELS - DEPTH - 1;

      node_type lft;
      node_type rgt;

      if (LEFT >= NUM_NODES) begin : g_leaf_kids
         assign lft = leaf_node[LEFT - NUM_NODES];
         assign rgt = leaf_node[RIGHT - NUM_NODES];
      end else begin : g_node_kids
         assign lft = node_ff[LEFT];
         assign rgt = node_ff[RIGHT];
      end

      always_comb begin
         if (rgt.live && (!lft.live || (rgt.dist_sq < lft.dist_sq))) begin
            node_in[n] = rgt;
         end else begin
            node_in[n] = lft;
         end
      end

      always_ff @(posedge clock) begin
         if (en[STAGE]) begin
            node_ff[n] <= node_in[n];
         end
      end
   end

   assign best = '{best_index: node_ff[0].idx, best_distance_sq: node_ff[0].dist_sq};

endmodule

// ----- design/weighted_nearest_codeword.sv -----
// ----------------------------------------------------------------------------
// weighted_nearest_codeword
// Nearest-codeword search over a constant codebook with per-dimension
// weights; returns the winning index and its weighted squared distance.
//
//   channel   direction  ports                           payload
//   req       in         req_valid, req_ready, req_data  req_type (five components)
//   rsp       out        rsp_valid, rsp_ready, rsp_data  rsp_type (index, distance)
//
// Throughput one transfer per cycle while the output is not stalled; the pipeline is an
// input register, the three distance stages and a stage for each tree level.
// Each stage holds its own valid bit and loads whenever it is empty or the next
// stage loads, so bubbles close up and a stalled output holds every stage.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module weighted_nearest_codeword #(
   parameter int NUM_CODEWORDS = wnc_pkg::DEF_NUM_CODEWORDS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wnc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output wnc_pkg::rsp_type rsp_data
);
   import wnc_pkg::*;

   localparam int NUM_ACTIVE  = (NUM_CODEWORDS < 1) ? 1 :
                                (NUM_CODEWORDS < ROM_SIZE) ? NUM_CODEWORDS : ROM_SIZE;
   localparam int TREE_LEVELS = $clog2(NUM_ACTIVE);
   localparam int NUM_STAGES  = 4 + TREE_LEVELS;

   logic [NUM_STAGES-1:0] en;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] valid_ff;

   comp_type          vec_in;
   comp_type          vec_ff;
   logic [DIST_W-1:0] cw_dist [NUM_ACTIVE];

   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   always_comb begin
      valid_in[0] = en[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign vec_in[0] = req_data.jaw_opening;
   assign vec_in[1] = req_data.tongue_rise;
   assign vec_in[2] = req_data.tongue_front;
   assign vec_in[3] = req_data.lip_round;
   assign vec_in[4] = req_data.corner_lift;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         vec_ff <= vec_in;
      end
   end

   for (genvar i = 0; i < NUM_ACTIVE; i++) begin : g_unit
      wnc_dist_unit u_dist (
         .clock    (clock),
         .en       (en[3:1]),
         .vec      (vec_ff),
         .codeword (CODEBOOK[i]),
         .dist_sq  (cw_dist[i])
      );
   end

   if (TREE_LEVELS > 0) begin : g_tree
      wnc_min_tree #(
         .NUM_LEAVES (NUM_ACTIVE)
      ) u_tree (
         .clock     (clock),
         .en        (en[NUM_STAGES-1:4]),
         .leaf_dist (cw_dist),
         .best      (rsp_data)
      );
   end else begin : g_single
      assign rsp_data = '{best_index: '0, best_distance_sq: cw_dist[0]};
   end

   assign req_ready = en[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

endmodule

// ----- bench/tb_weighted_nearest_codeword.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_nearest_codeword
// Self-checking bench for the weighted nearest-codeword search. Directed
// vectors cover the field extremes, every codeword hit exactly and tied
// midpoints. Random vectors follow: uniform, full 10-bit range, near a
// codeword and near the midpoint of two codewords. The sender works in
// bursts and the receiver stalls on its own pattern, with one long hold-off
// that backs up the pipe. Each result is checked against a local predictor
// of index and weighted squared distance.
// ----------------------------------------------------------------------------
module tb_weighted_nearest_codeword;
   import wnc_pkg::*;

   localparam int N_CW          = DEF_NUM_CODEWORDS;
   localparam int RANDOM_ITEMS  = 700;
   localparam int DRAIN_CYCLES  = 40;
   localparam int HOLD_CYCLES   = 200;
   localparam int HOLD_AFTER    = 200;
   localparam int MAX_REPORTS   = 10;

   class codeword_scoreboard;
      rsp_type     nearest_q[$];
      int unsigned accepted;
      int unsigned fail_count;
      int          codeword_count;

      function new(int count);
         codeword_count = count;
         accepted       = 0;
         fail_count     = 0;
      endfunction

      function rsp_type nearest_codeword(req_type v);
         logic [FIELD_W-1:0] comp [NUM_DIMS];
         logic [FIELD_W-1:0] cw;
         logic [FIELD_W-1:0] mag;
         logic [63:0]        wd;
         logic [63:0]        d;
         logic [63:0]        best_d;
         int                 best;
         int                 lim;
         rsp_type            res;
         comp[0] = v.jaw_opening;
         comp[1] = v.tongue_rise;
         comp[2] = v.tongue_front;
         comp[3] = v.lip_round;
         comp[4] = v.corner_lift;
         lim = (codeword_count < ROM_SIZE) ? codeword_count : ROM_SIZE;
         if (lim < 1) begin
            lim = 1;
         end
         best   = 0;
         best_d = '0;
         for (int r = 0; r < lim; r++) begin
            d = '0;
            for (int k = 0; k < NUM_DIMS; k++) begin
               cw  = CODEBOOK[r][k];
               mag = (comp[k] >= cw) ? comp[k] - cw : cw - comp[k];
               wd  = 64'(mag) * 64'(DIM_WEIGHT[k]);
               d   = d + wd * wd;
            end
            if (r == 0 || d < best_d) begin
               best_d = d;
               best   = r;
            end
         end
         res.best_index       = best[IDX_W-1:0];
         res.best_distance_sq = best_d[DIST_W-1:0];
         return res;
      endfunction

      function void note_vector(req_type v);
         nearest_q.push_back(nearest_codeword(v));
         accepted++;
      endfunction

      function void check_match(rsp_type got);
         rsp_type exp_r;
         if (nearest_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
               $display("unexpected result: index %0d dist %0d",
                        got.best_index, got.best_distance_sq);
            end
            return;
         end
         exp_r = nearest_q.pop_front();
         if (got.best_index != exp_r.best_index ||
             got.best_distance_sq != exp_r.best_distance_sq) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
               $display("mismatch: index %0d dist %0d, expected index %0d dist %0d",
                        got.best_index, got.best_distance_sq,
                        exp_r.best_index, exp_r.best_distance_sq);
            end
         end
      endfunction

      function int pending();
         return nearest_q.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   codeword_scoreboard sb = new(N_CW);
   req_type            vector_q[$];
   bit                 hold_done;

   weighted_nearest_codeword #(
      .NUM_CODEWORDS (N_CW)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic req_type make_vec(int a, int b, int c, int d, int e);
      return {FIELD_W'(a), FIELD_W'(b), FIELD_W'(c), FIELD_W'(d), FIELD_W'(e)};
   endfunction

   function automatic int clamp_comp(int x);
      if (x < 0) begin
         return 0;
      end
      if (x > 1023) begin
         return 1023;
      end
      return x;
   endfunction

   function automatic req_type random_vector();
      int pick;
      int ra;
      int rb;
      int c [NUM_DIMS];
      pick = $urandom_range(0, 99);
      ra   = $urandom_range(0, ROM_SIZE - 1);
      rb   = $urandom_range(0, ROM_SIZE - 1);
      for (int k = 0; k < NUM_DIMS; k++) begin
         if (pick < 40) begin
            c[k] = $urandom_range(0, 1000);
         end else if (pick < 55) begin
            c[k] = $urandom_range(0, 1023);
         end else if (pick < 85) begin
            c[k] = clamp_comp(int'(CODEBOOK[ra][k]) + $urandom_range(0, 120) - 60);
         end else begin
            c[k] = clamp_comp((int'(CODEBOOK[ra][k]) + int'(CODEBOOK[rb][k])) / 2
                              + $urandom_range(0, 4) - 2);
         end
      end
      return make_vec(c[0], c[1], c[2], c[3], c[4]);
   endfunction

   task automatic send_vector(input req_type v);
      req_valid <= 1'b1;
      req_data  <= v;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_vector(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_match(rsp_data);
         end
      end
   end

   initial begin
      int mode;
      int len;
      rsp_ready <= 1'b0;
      hold_done = 1'b0;
      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (!hold_done && sb.accepted >= HOLD_AFTER) begin
            rsp_ready <= 1'b0;
            for (int i = 0; i < HOLD_CYCLES; i++) begin
               @(posedge clock);
            end
            hold_done = 1'b1;
         end
         mode = $urandom_range(0, 3);
         len  = $urandom_range(16, 80);
         for (int i = 0; i < len; i++) begin
            case (mode)
               0: begin
                  rsp_ready <= 1'b1;
               end
               1: begin
                  rsp_ready <= ($urandom_range(0, 3) != 0);
               end
               2: begin
                  rsp_ready <= ($urandom_range(0, 1) != 0);
               end
               default: begin
                  rsp_ready <= ((i % 5) != 4) && ((i % 7) != 3);
               end
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      int burst;
      int gap;
      req_type v;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;

      vector_q.push_back(make_vec(0, 0, 0, 0, 0));
      vector_q.push_back(make_vec(1023, 1023, 1023, 1023, 1023));
      vector_q.push_back(make_vec(1000, 1000, 1000, 1000, 1000));
      vector_q.push_back(make_vec(1023, 0, 1023, 1023, 0));
      vector_q.push_back(make_vec(0, 1023, 0, 1023, 1023));
      for (int r = 0; r < ROM_SIZE; r++) begin
         vector_q.push_back(make_vec(CODEBOOK[r][0], CODEBOOK[r][1], CODEBOOK[r][2],
                                     CODEBOOK[r][3], CODEBOOK[r][4]));
      end
      vector_q.push_back(make_vec(500, 500, 900, 0, 500));
      vector_q.push_back(make_vec(450, 500, 600, 0, 500));
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         vector_q.push_back(random_vector());
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      while (vector_q.size() != 0) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && vector_q.size() != 0) begin
            v = vector_q.pop_front();
            send_vector(v);
            burst--;
         end
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 10);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.fail_count == 0 && sb.pending() == 0) begin
         $display("tb_weighted_nearest_codeword: done, clean");
      end else begin
         $display("tb_weighted_nearest_codeword: done, errors");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("tb_weighted_nearest_codeword: done, errors");
      $finish;
   end

endmodule
